// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/icmp_erc_pkg.sv -----
// Types and constants shared by the ICMP echo reply checker.
`default_nettype none
package icmp_erc_pkg;

  localparam int unsigned MaxPacketBytesDefault = 2048;
  localparam int unsigned TotalW = 12;
  localparam int unsigned HdrW   = 6;
  localparam int unsigned IcmpMinBytes = 8;

  localparam logic [7:0] IcmpEchoReply = 8'd0;

  localparam int unsigned OffType  = 0;
  localparam int unsigned OffIdLo  = 4;
  localparam int unsigned OffIdHi  = 5;
  localparam int unsigned OffSeqLo = 6;
  localparam int unsigned OffSeqHi = 7;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_TOO_SHORT = 2'd1,
    VERDICT_WRONG_ID  = 2'd2,
    VERDICT_NOT_REPLY = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [15:0]       sequence_res;
    logic [TotalW-1:0] total_bytes;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/icmp_erc_ifs.sv -----
// Valid/ready channel interfaces for input, result and configuration.
`default_nettype none
interface icmp_erc_in_if import icmp_erc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icmp_erc_out_if import icmp_erc_pkg::*; ();
  logic              valid;
  logic              ready;
  verdict_e          verdict;
  logic [15:0]       sequence_res;
  logic [TotalW-1:0] total_bytes;

  modport source (output valid, output verdict, output sequence_res, output total_bytes,
                  input ready);
  modport sink   (input valid, input verdict, input sequence_res, input total_bytes,
                  output ready);
endinterface

interface icmp_erc_cfg_if import icmp_erc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] own_identifier;

  modport source (output valid, output own_identifier, input ready);
  modport sink   (input valid, input own_identifier, output ready);
endinterface
`default_nettype wire

// ----- rtl/icmp_echo_reply_checker_top.sv -----
// A last byte is held in the input register until the result register is free; its verdict is then loaded there.
// Throughput: one byte transaction per cycle; the input register and result register
// overlap, so a byte is taken while a verdict waits, stalling only on a last byte.
// Reset: rst_ni async active low clears the parse state, both valid flags and the
// configured identifier (to zero).
`default_nettype none
`include "assert_macros.svh"
module icmp_echo_reply_checker_top import icmp_erc_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  icmp_erc_cfg_if.sink   cfg_chan,
  icmp_erc_in_if.sink    in_chan,
  icmp_erc_out_if.source out_chan
);

  logic [15:0] own_id_q;
  logic        in_fire;
  logic        item_vld;
  item_t       item_in, item;
  logic        adv;
  logic        par_load;
  logic        out_vld;
  res_t        par_res, out_res;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_chan.valid) begin
      own_id_q <= cfg_chan.own_identifier;
    end
  end

  assign item_in.data_byte = in_chan.data_byte;
  assign item_in.last_byte = in_chan.last_byte;

  assign adv      = item_vld && (!item.last_byte || !out_vld || out_chan.ready);
  assign par_load = adv && item.last_byte;
  assign in_chan.ready = !item_vld || adv;
  assign in_fire  = in_chan.valid && in_chan.ready;

  icmp_erc_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (item_in),
    .adv_i  (adv),
    .vld_o  (item_vld),
    .item_o (item)
  );

  icmp_erc_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (item),
    .own_id_i (own_id_q),
    .res_o    (par_res)
  );

  icmp_erc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (par_load),
    .res_i   (par_res),
    .ready_i (out_chan.ready),
    .vld_o   (out_vld),
    .res_o   (out_res)
  );

  assign out_chan.valid        = out_vld;
  assign out_chan.verdict      = out_res.verdict;
  assign out_chan.sequence_res = out_res.sequence_res;
  assign out_chan.total_bytes  = out_res.total_bytes;

  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, par_load && out_vld && !out_chan.ready, "result overwritten before taken")
  `ASSERT_PROP(a_rise_from_last, clk_i, rst_ni, $rose(out_vld) |-> $past(par_load), "result valid without last byte")
  `ASSERT_PROP(a_item_held, clk_i, rst_ni, (item_vld && !adv) |=> item_vld, "stalled byte dropped")

endmodule
`default_nettype wire

// ----- rtl/icmp_erc_in_stage.sv -----
// Input register holding one accepted byte transaction.
`default_nettype none
module icmp_erc_in_stage import icmp_erc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  logic  adv_i,
  output logic  vld_o,
  output item_t item_o
);

  logic  vld_d, vld_q;
  item_t item_q;

  always_comb begin
    vld_d = vld_q;
    if (fire_i) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

// ----- rtl/icmp_erc_parser.sv -----
// Per-packet parse state and verdict logic.
`default_nettype none
module icmp_erc_parser import icmp_erc_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  item_t       item_i,
  input  logic [15:0] own_id_i,
  output res_t        res_o
);

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PACKET_BYTES);

  logic [CntW-1:0] cnt_d, cnt_q;
  logic [HdrW-1:0] hdr_d, hdr_q;
  logic [7:0]      type_d, type_q;
  logic [15:0]     id_d, id_q;
  logic [15:0]     seq_d, seq_q;
  logic [CntW-1:0] off;
  logic            in_msg;
  logic            sat;

  always_comb begin
    cnt_d  = cnt_q;
    hdr_d  = hdr_q;
    type_d = type_q;
    id_d   = id_q;
    seq_d  = seq_q;
    sat    = (cnt_q == MaxCnt);
    if (!sat && (cnt_q == '0)) begin
      hdr_d = {item_i.data_byte[3:0], 2'b00};
    end
    in_msg = (cnt_q >= CntW'(hdr_d));
    off    = cnt_q - CntW'(hdr_d);
    if (!sat) begin
      cnt_d = cnt_q + CntW'(1);
      if (in_msg) begin
        unique case (off)
          CntW'(OffType):  type_d      = item_i.data_byte;
          CntW'(OffIdLo):  id_d[7:0]   = item_i.data_byte;
          CntW'(OffIdHi):  id_d[15:8]  = item_i.data_byte;
          CntW'(OffSeqLo): seq_d[7:0]  = item_i.data_byte;
          CntW'(OffSeqHi): seq_d[15:8] = item_i.data_byte;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    priority if (cnt_d < (CntW'(hdr_d) + CntW'(IcmpMinBytes))) begin
      res_o.verdict = VERDICT_TOO_SHORT;
    end else if (id_d != own_id_i) begin
      res_o.verdict = VERDICT_WRONG_ID;
    end else if (type_d != IcmpEchoReply) begin
      res_o.verdict = VERDICT_NOT_REPLY;
    end else begin
      res_o.verdict = VERDICT_ACCEPT;
    end
    res_o.sequence_res = seq_d;
    res_o.total_bytes  = TotalW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hdr_q  <= '0;
      type_q <= '0;
      id_q   <= '0;
      seq_q  <= '0;
    end else if (adv_i) begin
      if (item_i.last_byte) begin
        cnt_q  <= '0;
        hdr_q  <= '0;
        type_q <= '0;
        id_q   <= '0;
        seq_q  <= '0;
      end else begin
        cnt_q  <= cnt_d;
        hdr_q  <= hdr_d;
        type_q <= type_d;
        id_q   <= id_d;
        seq_q  <= seq_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/icmp_erc_out_stage.sv -----
// Result register toward the output channel.
`default_nettype none
module icmp_erc_out_stage import icmp_erc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic vld_o,
  output res_t res_o
);

  logic vld_d, vld_q;
  res_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

// ----- test/icmp_verdict_checker.sv -----
// Checker: predicts ICMP echo reply verdicts from observed byte transactions and compares.
`timescale 1ns / 100ps
module icmp_verdict_checker import icmp_erc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [15:0]       cfg_own_id_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_data_i,
  input  logic              in_last_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  verdict_e          out_verdict_i,
  input  logic [15:0]       out_sequence_i,
  input  logic [TotalW-1:0] out_total_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  logic [TotalW-1:0] byte_cnt;
  logic [HdrW-1:0]   hdr_len;
  logic [7:0]        msg_type;
  logic [15:0]       msg_id;
  logic [15:0]       msg_seq;
  logic [15:0]       own_id;
  res_t              verdict_q[$];

  task automatic clear_packet();
    byte_cnt = '0;
    hdr_len  = '0;
    msg_type = '0;
    msg_id   = '0;
    msg_seq  = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned off;
    res_t        want;
    if (byte_cnt < MaxPacketBytesDefault) begin
      if (byte_cnt == 0) hdr_len = {b[3:0], 2'b00};
      if (byte_cnt >= hdr_len) begin
        off = byte_cnt - hdr_len;
        case (off)
          OffType:  msg_type      = b;
          OffIdLo:  msg_id[7:0]   = b;
          OffIdHi:  msg_id[15:8]  = b;
          OffSeqLo: msg_seq[7:0]  = b;
          OffSeqHi: msg_seq[15:8] = b;
          default: ;
        endcase
      end
      byte_cnt++;
    end
    if (last) begin
      if (byte_cnt < hdr_len + IcmpMinBytes) want.verdict = VERDICT_TOO_SHORT;
      else if (msg_id != own_id)              want.verdict = VERDICT_WRONG_ID;
      else if (msg_type != IcmpEchoReply)     want.verdict = VERDICT_NOT_REPLY;
      else                                    want.verdict = VERDICT_ACCEPT;
      want.sequence_res = msg_seq;
      want.total_bytes  = byte_cnt;
      verdict_q.push_back(want);
      clear_packet();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t got;
    res_t want;
    if (!rst_ni) begin
      own_id = '0;
      clear_packet();
      verdict_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) own_id = cfg_own_id_i;
      if (out_valid_i && out_ready_i) begin
        got.verdict      = out_verdict_i;
        got.sequence_res = out_sequence_i;
        got.total_bytes  = out_total_i;
        if (verdict_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected verdict transaction: verdict=%s seq=%h total=%0d",
                     $realtime, got.verdict.name(), got.sequence_res, got.total_bytes);
        end else begin
          want = verdict_q.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: verdict exp %s/%h/%0d got %s/%h/%0d", $realtime,
                       want.verdict.name(), want.sequence_res, want.total_bytes,
                       got.verdict.name(), got.sequence_res, got.total_bytes);
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_byte(in_data_i, in_last_i);
    end
    pending_o = verdict_q.size();
  end

endmodule

// ----- test/tb_icmp_echo_reply_checker_top.sv -----
// Testbench top: drives packets and identifier writes into the ICMP echo reply checker.
`timescale 1ns / 100ps
module tb_icmp_echo_reply_checker_top import icmp_erc_pkg::*;;

  localparam int unsigned CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned rnd_bytes;
  int unsigned rnd_pkts;
  int unsigned rdy_cycle;
  int unsigned rdy_mode;
  logic [15:0] rdy_mask;
  logic [15:0] cur_own;
  logic [7:0]  pkt_q[$];

  icmp_erc_cfg_if cfg_chan ();
  icmp_erc_in_if  in_chan ();
  icmp_erc_out_if out_chan ();

  icmp_echo_reply_checker_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_chan(cfg_chan),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  icmp_verdict_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_chan.valid),
    .cfg_ready_i   (cfg_chan.ready),
    .cfg_own_id_i  (cfg_chan.own_identifier),
    .in_valid_i    (in_chan.valid),
    .in_ready_i    (in_chan.ready),
    .in_data_i     (in_chan.data_byte),
    .in_last_i     (in_chan.last_byte),
    .out_valid_i   (out_chan.valid),
    .out_ready_i   (out_chan.ready),
    .out_verdict_i (out_chan.verdict),
    .out_sequence_i(out_chan.sequence_res),
    .out_total_i   (out_chan.total_bytes),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("icmp_echo_reply_checker_top: mismatch");
    $finish;
  end

  // receiver stall pattern, re-chosen at random among three modes
  initial begin
    rdy_cycle = 0;
    rdy_mode  = 0;
    rdy_mask  = 16'hFFFF;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rdy_cycle++;
      if (rdy_cycle % 97 == 0) begin
        rdy_mode = $urandom_range(0, 2);
        rdy_mask = 16'($urandom) | 16'h0001;
      end
      case (rdy_mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= 1'($urandom_range(0, 1));
        default: out_chan.ready <= rdy_mask[4'(rdy_cycle % 16)];
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(10, 25);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_queue();
    for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic send_packet(input int unsigned ihl, input int unsigned len,
                             input logic [7:0] typ, input logic [15:0] id,
                             input logic [15:0] seq);
    int unsigned hdr;
    hdr = ihl * 4;
    pkt_q.delete();
    for (int i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
    pkt_q[0][3:0] = ihl[3:0];
    if (hdr + 0 < len) pkt_q[hdr + 0] = typ;
    if (hdr + 4 < len) pkt_q[hdr + 4] = id[7:0];
    if (hdr + 5 < len) pkt_q[hdr + 5] = id[15:8];
    if (hdr + 6 < len) pkt_q[hdr + 6] = seq[7:0];
    if (hdr + 7 < len) pkt_q[hdr + 7] = seq[15:8];
    send_queue();
  endtask

  task automatic send_noise(input int unsigned len);
    pkt_q.delete();
    for (int i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
    send_queue();
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_id(input logic [15:0] v);
    wait_idle();
    cur_own = v;
    cfg_chan.valid          <= 1'b1;
    cfg_chan.own_identifier <= v;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic send_random_packet();
    int unsigned ihl;
    int unsigned icmp_len;
    logic [7:0]  typ;
    logic [15:0] id;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: ihl = 5;
      5, 6, 7:       ihl = $urandom_range(0, 2);
      default:       ihl = $urandom_range(0, 15);
    endcase
    icmp_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 20);
    typ = ($urandom_range(0, 9) < 6) ? IcmpEchoReply : 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: id = cur_own;
      6:                id = cur_own ^ (16'h0001 << $urandom_range(0, 15));
      default:          id = 16'($urandom);
    endcase
    if (ihl * 4 + icmp_len == 0) icmp_len = 1;
    send_packet(ihl, ihl * 4 + icmp_len, typ, id, 16'($urandom));
  endtask

  initial begin
    burst_left = 0;
    rnd_bytes  = 0;
    rnd_pkts   = 0;
    cur_own    = '0;
    rst_n                   <= 1'b0;
    cfg_chan.valid          <= 1'b0;
    cfg_chan.own_identifier <= '0;
    in_chan.valid           <= 1'b0;
    in_chan.data_byte       <= '0;
    in_chan.last_byte       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_own_id(16'h0000);
    send_packet(5, 28, IcmpEchoReply, 16'h0000, 16'h1234);
    send_packet(5, 28, IcmpEchoReply, 16'h0001, 16'h5678);
    send_packet(5, 28, 8'd8, 16'h0000, 16'h9abc);
    send_packet(5, 28, 8'd8, 16'h8000, 16'h0001);
    send_packet(5, 27, IcmpEchoReply, 16'h0000, 16'hbeef);
    send_packet(5, 24, IcmpEchoReply, 16'h0000, 16'hbeef);
    send_packet(5, 27, IcmpEchoReply, 16'h4321, 16'h1111);
    send_packet(15, 10, IcmpEchoReply, 16'h0000, 16'h2222);
    send_packet(15, 68, IcmpEchoReply, 16'h0000, 16'h3333);
    send_packet(0, 8, IcmpEchoReply, 16'h0000, 16'hFFFF);
    send_packet(5, 1, IcmpEchoReply, 16'h0000, 16'h0000);
    send_packet(1, 12, IcmpEchoReply, 16'h0000, 16'h00FF);
    send_packet(1, 11, IcmpEchoReply, 16'h0000, 16'hFF00);

    write_own_id(16'hFFFF);
    send_packet(5, 28, IcmpEchoReply, 16'hFFFF, 16'h0000);
    send_packet(5, 28, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_packet(5, 28, IcmpEchoReply, 16'hFF00, 16'hA5A5);

    while (rnd_bytes < 470) begin
      if (rnd_pkts % 8 == 0) begin
        case ($urandom_range(0, 3))
          0:       write_own_id(16'h0000);
          1:       write_own_id(16'hFFFF);
          default: write_own_id(16'($urandom));
        endcase
      end
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 40));
      else send_random_packet();
      rnd_bytes += pkt_q.size();
      rnd_pkts++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("icmp_echo_reply_checker_top: match");
    else $display("icmp_echo_reply_checker_top: mismatch");
    $finish;
  end

endmodule
